// ===== sv/prc_pkg.sv =====
// ---------------------------------------------------------------------------
// Polar/rectangular converter package
// Shared types, fixed-point constants and the arctangent table of the
// converter's rotation cells.
// ---------------------------------------------------------------------------
package prc_pkg;

  // Command codes carried in tuser.
  localparam logic CMD_RECT_TO_POLAR = 1'b0;
  localparam logic CMD_POLAR_TO_RECT = 1'b1;

  // Angles in 1/64 degree.
  localparam int QUARTER_TURN = 5760;
  localparam int HALF_TURN    = 11520;
  localparam int FULL_TURN    = 23040;

  // Width of an angle in 1/64 degree that holds a full turn, signed.
  localparam int ANGLE_W = 16;

  // The angle accumulator is in degree * 2^22, i.e. 1/64 degree * 2^16.
  localparam int ZW          = 32;
  localparam int ANGLE_SHIFT = 16;

  // Lengths in the rotation datapath are Q7.8 values scaled by 2^30.
  localparam int FRAC_SHIFT = 30;
  localparam int XW_EXTRA   = 33;

  // Rotation gain compensation, 0.60725293500888 in Q30.
  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

  // Control and status that travel with each word down the pipeline.
  typedef struct packed {
    logic valid;
    logic cmd;
    logic a_zero;
    logic b_zero;
    logic b_neg;
  } prc_tag_t;

  // atan(2^-i) in degree * 2^22.
  function automatic logic signed [31:0] atan_entry(input int idx);
    logic signed [31:0] v;
    case (idx)
      0:  v = 32'sd188743680;
      1:  v = 32'sd111421900;
      2:  v = 32'sd58872272;
      3:  v = 32'sd29884485;
      4:  v = 32'sd15000234;
      5:  v = 32'sd7507429;
      6:  v = 32'sd3754631;
      7:  v = 32'sd1877430;
      8:  v = 32'sd938729;
      9:  v = 32'sd469366;
      10: v = 32'sd234683;
      11: v = 32'sd117342;
      12: v = 32'sd58671;
      13: v = 32'sd29335;
      14: v = 32'sd14668;
      15: v = 32'sd7334;
      16: v = 32'sd3667;
      17: v = 32'sd1833;
      18: v = 32'sd917;
      19: v = 32'sd458;
      20: v = 32'sd229;
      21: v = 32'sd115;
      22: v = 32'sd57;
      23: v = 32'sd29;
      24: v = 32'sd14;
      25: v = 32'sd7;
      26: v = 32'sd4;
      27: v = 32'sd2;
      28: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // Number of conditional add or subtract steps that bring a w-bit signed angle
  // into one full turn either side of zero.
  function automatic int wrap_steps(input int w);
    int     k;
    longint span;
    k    = 0;
    span = longint'(FULL_TURN);
    while (span < (longint'(1) << (w - 1))) begin
      span = span << 1;
      k++;
    end
    return k;
  endfunction

  // Width of the angle register during reduction: the wider of the input and a full turn, plus one bit.
  function automatic int turn_width(input int w);
    return ((w > ANGLE_W) ? w : ANGLE_W) + 1;
  endfunction

  // Bit count rounded up to whole bytes.
  function automatic int byte_pad(input int bits);
    return ((bits + 7) >> 3) << 3;
  endfunction

endpackage

// ===== sv/polar_rectangular_converter.sv =====
// ---------------------------------------------------------------------------
// Polar/rectangular converter
// Converts one word per clock, while s_tready is high, between rectangular
// and polar form. Command 0 takes base and height (signed Q7.8) and returns
// the rounded hypotenuse and atan(height/base) in 1/64 degree, limited to
// +-90 degrees, flagging the all-zero input as an invalid angle. Command 1
// takes a hypotenuse and an angle in 1/64 degree and returns base and height
// rounded to Q7.8. A new word is taken every cycle while s_tready is high.
// A word passes a short row of angle reduction cells (one at 16 bits), four
// setup stages for folding, the multiplies and the radicand sum, and then
// the row of rotation/root cells, one CORDIC step and one root digit per
// cell. A two-word output buffer lets the input side keep going while a
// result waits; s_tready drops only once a second result is held.
// ---------------------------------------------------------------------------
module polar_rectangular_converter #(
  parameter int DATA_WIDTH     = 16,
  parameter int ROTATION_STEPS = 16
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              s_tvalid,
  output logic                                              s_tready,
  // first_value, second_value
  input  logic [prc_pkg::byte_pad(2*DATA_WIDTH)-1:0]        s_tdata,
  // command
  input  logic                                              s_tuser,
  output logic                                              m_tvalid,
  input  logic                                              m_tready,
  // first_result, second_result, zero fill
  output logic [prc_pkg::byte_pad(2*(DATA_WIDTH+1))-1:0]    m_tdata,
  // angle_invalid
  output logic                                              m_tuser
);

  localparam int W  = DATA_WIDTH;
  localparam int OW = DATA_WIDTH + 1;
  localparam int TW = prc_pkg::turn_width(DATA_WIDTH);
  localparam int XW = DATA_WIDTH + prc_pkg::XW_EXTRA;
  localparam int ZW = prc_pkg::ZW;
  localparam int AW = prc_pkg::ANGLE_W;
  localparam int K  = prc_pkg::wrap_steps(DATA_WIDTH);
  localparam int L  = (ROTATION_STEPS > DATA_WIDTH) ? ROTATION_STEPS : DATA_WIDTH;
  localparam int OUT_TDATA_W = prc_pkg::byte_pad(2 * OW);

  localparam logic signed [TW-1:0] FULL_T    = TW'(prc_pkg::FULL_TURN);
  localparam logic signed [TW-1:0] HALF_T    = TW'(prc_pkg::HALF_TURN);
  localparam logic signed [TW-1:0] QUARTER_T = TW'(prc_pkg::QUARTER_TURN);
  localparam logic signed [AW-1:0] QUARTER_A = AW'(prc_pkg::QUARTER_TURN);
  localparam logic signed [XW-1:0] RND_X     = XW'(1) <<< (prc_pkg::FRAC_SHIFT - 1);
  localparam logic signed [ZW-1:0] RND_Z     = ZW'(1) <<< (prc_pkg::ANGLE_SHIFT - 1);

  logic adv;
  logic skid_valid;

  assign adv      = !skid_valid;
  assign s_tready = adv;

  // Input stage.
  logic signed [W-1:0] in_a;
  logic signed [W-1:0] in_b;
  prc_pkg::prc_tag_t   tag_s0;
  logic signed [W-1:0] a_s0;
  logic signed [W-1:0] b_s0;

  assign in_a = s_tdata[W-1:0];
  assign in_b = s_tdata[2*W-1:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_s0 <= '0;
    end else if (adv) begin
      tag_s0.valid  <= s_tvalid;
      tag_s0.cmd    <= s_tuser;
      tag_s0.a_zero <= (in_a == '0);
      tag_s0.b_zero <= (in_b == '0);
      tag_s0.b_neg  <= in_b[W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_s0 <= in_a;
      b_s0 <= in_b;
    end
  end

  // Angle reduction row.
  prc_pkg::prc_tag_t    tag_w [K+1];
  logic signed [W-1:0]  a_w   [K+1];
  logic signed [W-1:0]  b_w   [K+1];
  logic signed [TW-1:0] th_w  [K+1];

  assign tag_w[0] = tag_s0;
  assign a_w[0]   = a_s0;
  assign b_w[0]   = b_s0;
  assign th_w[0]  = TW'(b_s0);

  for (genvar j = 0; j < K; j++) begin : g_wrap
    prc_wrap_cell #(
      .DATA_WIDTH(W),
      .SHIFT     (K - 1 - j)
    ) u_wrap (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .tag_in (tag_w[j]),
      .a_in   (a_w[j]),
      .b_in   (b_w[j]),
      .th_in  (th_w[j]),
      .tag_out(tag_w[j+1]),
      .a_out  (a_w[j+1]),
      .b_out  (b_w[j+1]),
      .th_out (th_w[j+1])
    );
  end

  // Half-turn fold: the angle ends in [-180, 180) degrees.
  prc_pkg::prc_tag_t    tag_f;
  logic signed [W-1:0]  a_f;
  logic signed [W-1:0]  b_f;
  logic signed [TW-1:0] th_f;
  logic signed [TW-1:0] th_half;

  always_comb begin
    if (th_w[K] >= HALF_T) begin
      th_half = th_w[K] - FULL_T;
    end else if (th_w[K] < -HALF_T) begin
      th_half = th_w[K] + FULL_T;
    end else begin
      th_half = th_w[K];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_f <= '0;
    end else if (adv) begin
      tag_f <= tag_w[K];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_f  <= a_w[K];
      b_f  <= b_w[K];
      th_f <= th_half;
    end
  end

  // Quarter-turn fold and sign handling. Angles beyond +-90 degrees move by
  // half a turn and flip the length; a negative base flips both inputs.
  prc_pkg::prc_tag_t    tag_g;
  logic signed [OW-1:0] a_g;
  logic signed [OW-1:0] b_g;
  logic signed [TW-1:0] th_g;
  logic                 q_hi;
  logic                 q_lo;
  logic                 p2r_f;
  logic                 neg_a;
  logic                 neg_b;
  logic signed [OW-1:0] a_wide;
  logic signed [OW-1:0] b_wide;
  logic signed [TW-1:0] th_quarter;

  assign q_hi   = th_f > QUARTER_T;
  assign q_lo   = th_f < -QUARTER_T;
  assign p2r_f  = tag_f.cmd == prc_pkg::CMD_POLAR_TO_RECT;
  assign neg_a  = p2r_f ? (q_hi || q_lo) : a_f[W-1];
  assign neg_b  = !p2r_f && a_f[W-1];
  assign a_wide = OW'(a_f);
  assign b_wide = OW'(b_f);

  always_comb begin
    if (q_hi) begin
      th_quarter = th_f - HALF_T;
    end else if (q_lo) begin
      th_quarter = th_f + HALF_T;
    end else begin
      th_quarter = th_f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_g <= '0;
    end else if (adv) begin
      tag_g <= tag_f;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_g  <= neg_a ? -a_wide : a_wide;
      b_g  <= neg_b ? -b_wide : b_wide;
      th_g <= th_quarter;
    end
  end

  // Squares for the radicand, gain-compensated start vector for rotation.
  prc_pkg::prc_tag_t      tag_m;
  logic [2*W-1:0]         aa_m;
  logic [2*W-1:0]         bb_m;
  logic signed [XW-1:0]   x_m;
  logic signed [XW-1:0]   y_m;
  logic signed [ZW-1:0]   z_m;
  logic signed [2*OW-1:0] aa_full;
  logic signed [2*OW-1:0] bb_full;
  logic signed [XW-1:0]   x_gain;
  logic                   p2r_g;

  assign aa_full = a_g * a_g;
  assign bb_full = b_g * b_g;
  assign x_gain  = a_g * prc_pkg::GAIN_Q30;
  assign p2r_g   = tag_g.cmd == prc_pkg::CMD_POLAR_TO_RECT;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_m <= '0;
    end else if (adv) begin
      tag_m <= tag_g;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      aa_m <= aa_full[2*W-1:0];
      bb_m <= bb_full[2*W-1:0];
      x_m  <= p2r_g ? x_gain : (XW'(a_g) <<< prc_pkg::FRAC_SHIFT);
      y_m  <= p2r_g ? '0 : (XW'(b_g) <<< prc_pkg::FRAC_SHIFT);
      z_m  <= p2r_g ? (ZW'(th_g) <<< prc_pkg::ANGLE_SHIFT) : '0;
    end
  end

  // Radicand sum.
  prc_pkg::prc_tag_t    tag_q;
  logic [2*W-1:0]       n_q;
  logic signed [XW-1:0] x_q;
  logic signed [XW-1:0] y_q;
  logic signed [ZW-1:0] z_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q <= '0;
    end else if (adv) begin
      tag_q <= tag_m;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_q <= aa_m + bb_m;
      x_q <= x_m;
      y_q <= y_m;
      z_q <= z_m;
    end
  end

  // Rotation/root row.
  prc_pkg::prc_tag_t    tag_c  [L+1];
  logic signed [XW-1:0] x_c    [L+1];
  logic signed [XW-1:0] y_c    [L+1];
  logic signed [ZW-1:0] z_c    [L+1];
  logic [2*W-1:0]       n_c    [L+1];
  logic [W-1:0]         root_c [L+1];
  logic [W+1:0]         rem_c  [L+1];

  assign tag_c[0]  = tag_q;
  assign x_c[0]    = x_q;
  assign y_c[0]    = y_q;
  assign z_c[0]    = z_q;
  assign n_c[0]    = n_q;
  assign root_c[0] = '0;
  assign rem_c[0]  = '0;

  for (genvar i = 0; i < L; i++) begin : g_cell
    prc_cell #(
      .STEP          (i),
      .DATA_WIDTH    (W),
      .ROTATION_STEPS(ROTATION_STEPS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tag_in  (tag_c[i]),
      .x_in    (x_c[i]),
      .y_in    (y_c[i]),
      .z_in    (z_c[i]),
      .n_in    (n_c[i]),
      .root_in (root_c[i]),
      .rem_in  (rem_c[i]),
      .tag_out (tag_c[i+1]),
      .x_out   (x_c[i+1]),
      .y_out   (y_c[i+1]),
      .z_out   (z_c[i+1]),
      .n_out   (n_c[i+1]),
      .root_out(root_c[i+1]),
      .rem_out (rem_c[i+1])
    );
  end

  // Rounding and result selection.
  prc_pkg::prc_tag_t    tag_e;
  logic                 p2r_e;
  logic [OW-1:0]        hyp;
  logic signed [XW-1:0] x_rnd;
  logic signed [XW-1:0] y_rnd;
  logic signed [ZW-1:0] z_rnd;
  logic signed [AW-1:0] z_deg;
  logic signed [AW-1:0] z_clamp;
  logic signed [AW-1:0] angle;
  logic                 r_valid;
  logic [OW-1:0]        r_first;
  logic [OW-1:0]        r_second;
  logic                 r_inv;

  assign tag_e = tag_c[L];
  assign p2r_e = tag_e.cmd == prc_pkg::CMD_POLAR_TO_RECT;
  // Round the root to nearest: step up when the remainder exceeds the root.
  assign hyp   = (rem_c[L] > {2'b00, root_c[L]}) ? {1'b0, root_c[L]} + 1'b1
                                                 : {1'b0, root_c[L]};
  assign x_rnd = x_c[L] + RND_X;
  assign y_rnd = y_c[L] + RND_X;
  assign z_rnd = z_c[L] + RND_Z;
  assign z_deg = z_rnd[ZW-1:prc_pkg::ANGLE_SHIFT];

  always_comb begin
    if (z_deg > QUARTER_A) begin
      z_clamp = QUARTER_A;
    end else if (z_deg < -QUARTER_A) begin
      z_clamp = -QUARTER_A;
    end else begin
      z_clamp = z_deg;
    end
    if (!tag_e.a_zero) begin
      angle = z_clamp;
    end else if (tag_e.b_zero) begin
      angle = '0;
    end else if (tag_e.b_neg) begin
      angle = -QUARTER_A;
    end else begin
      angle = QUARTER_A;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (adv) begin
      r_valid <= tag_e.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_first  <= p2r_e ? x_rnd[prc_pkg::FRAC_SHIFT +: OW] : hyp;
      r_second <= p2r_e ? y_rnd[prc_pkg::FRAC_SHIFT +: OW] : OW'(angle);
      r_inv    <= !p2r_e && tag_e.a_zero && tag_e.b_zero;
    end
  end

  // Output register with one skid word behind it.
  logic [OW-1:0] out_first;
  logic [OW-1:0] out_second;
  logic          out_inv;
  logic [OW-1:0] skid_first;
  logic [OW-1:0] skid_second;
  logic          skid_inv;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
        out_first  <= skid_first;
        out_second <= skid_second;
        out_inv    <= skid_inv;
      end
    end else if (r_valid) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid   <= 1'b1;
        out_first  <= r_first;
        out_second <= r_second;
        out_inv    <= r_inv;
      end else begin
        skid_valid  <= 1'b1;
        skid_first  <= r_first;
        skid_second <= r_second;
        skid_inv    <= r_inv;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = OUT_TDATA_W'({out_second, out_first});
  assign m_tuser = out_inv;

endmodule

// ===== sv/prc_wrap_cell.sv =====
// ---------------------------------------------------------------------------
// Angle reduction cell
// One conditional add or subtract of a full turn scaled by 2^SHIFT, with the
// rest of the word passed along unchanged.
// ---------------------------------------------------------------------------
module prc_wrap_cell #(
  parameter int DATA_WIDTH = 16,
  parameter int SHIFT      = 0
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                adv,
  input  prc_pkg::prc_tag_t                                   tag_in,
  input  logic signed [DATA_WIDTH-1:0]                        a_in,
  input  logic signed [DATA_WIDTH-1:0]                        b_in,
  input  logic signed [prc_pkg::turn_width(DATA_WIDTH)-1:0]   th_in,
  output prc_pkg::prc_tag_t                                   tag_out,
  output logic signed [DATA_WIDTH-1:0]                        a_out,
  output logic signed [DATA_WIDTH-1:0]                        b_out,
  output logic signed [prc_pkg::turn_width(DATA_WIDTH)-1:0]   th_out
);

  localparam int TW = prc_pkg::turn_width(DATA_WIDTH);
  localparam logic signed [TW-1:0] STEP_C = TW'(longint'(prc_pkg::FULL_TURN) << SHIFT);

  logic signed [TW-1:0] th_next;

  always_comb begin
    if (th_in >= STEP_C) begin
      th_next = th_in - STEP_C;
    end else if (th_in < -STEP_C) begin
      th_next = th_in + STEP_C;
    end else begin
      th_next = th_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (adv) begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_out  <= a_in;
      b_out  <= b_in;
      th_out <= th_next;
    end
  end

endmodule

// ===== sv/prc_cell.sv =====
// ---------------------------------------------------------------------------
// Rotation and root cell
// Up to one CORDIC micro-rotation (vectoring or rotation by command) and one
// restoring square root digit, per STEP, registered toward the next cell.
// ---------------------------------------------------------------------------
module prc_cell #(
  parameter int STEP           = 0,
  parameter int DATA_WIDTH     = 16,
  parameter int ROTATION_STEPS = 16
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             adv,
  input  prc_pkg::prc_tag_t                                tag_in,
  input  logic signed [DATA_WIDTH+prc_pkg::XW_EXTRA-1:0]   x_in,
  input  logic signed [DATA_WIDTH+prc_pkg::XW_EXTRA-1:0]   y_in,
  input  logic signed [prc_pkg::ZW-1:0]                    z_in,
  input  logic [2*DATA_WIDTH-1:0]                          n_in,
  input  logic [DATA_WIDTH-1:0]                            root_in,
  input  logic [DATA_WIDTH+1:0]                            rem_in,
  output prc_pkg::prc_tag_t                                tag_out,
  output logic signed [DATA_WIDTH+prc_pkg::XW_EXTRA-1:0]   x_out,
  output logic signed [DATA_WIDTH+prc_pkg::XW_EXTRA-1:0]   y_out,
  output logic signed [prc_pkg::ZW-1:0]                    z_out,
  output logic [2*DATA_WIDTH-1:0]                          n_out,
  output logic [DATA_WIDTH-1:0]                            root_out,
  output logic [DATA_WIDTH+1:0]                            rem_out
);

  localparam int W  = DATA_WIDTH;
  localparam int XW = DATA_WIDTH + prc_pkg::XW_EXTRA;
  localparam int ZW = prc_pkg::ZW;
  localparam int NW = 2 * DATA_WIDTH;

  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic signed [ZW-1:0] z_next;
  logic [W-1:0]         root_next;
  logic [W+1:0]         rem_next;

  if (STEP < ROTATION_STEPS) begin : g_rot
    localparam logic signed [ZW-1:0] ATAN_STEP = prc_pkg::atan_entry(STEP);
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 ccw;

    assign dx = y_in >>> STEP;
    assign dy = x_in >>> STEP;
    // Rotation drives the residual angle to zero, vectoring drives y to zero.
    assign ccw = (tag_in.cmd == prc_pkg::CMD_POLAR_TO_RECT) ? !z_in[ZW-1] : y_in[XW-1];

    always_comb begin
      if (ccw) begin
        x_next = x_in - dx;
        y_next = y_in + dy;
        z_next = z_in - ATAN_STEP;
      end else begin
        x_next = x_in + dx;
        y_next = y_in - dy;
        z_next = z_in + ATAN_STEP;
      end
    end
  end else begin : g_rot_pass
    assign x_next = x_in;
    assign y_next = y_in;
    assign z_next = z_in;
  end

  if (STEP < W) begin : g_root
    logic [W+1:0] rem_sh;
    logic [W+1:0] trial;
    logic         fits;

    // Bring down the next pair of radicand bits and try a one digit.
    assign rem_sh    = {rem_in[W-1:0], n_in[NW-1-2*STEP -: 2]};
    assign trial     = {root_in, 2'b01};
    assign fits      = rem_sh >= trial;
    assign rem_next  = fits ? rem_sh - trial : rem_sh;
    assign root_next = {root_in[W-2:0], fits};
  end else begin : g_root_pass
    assign rem_next  = rem_in;
    assign root_next = root_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (adv) begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= z_next;
      n_out    <= n_in;
      root_out <= root_next;
      rem_out  <= rem_next;
    end
  end

endmodule

// ===== sv/prc_checker.sv =====
// ---------------------------------------------------------------------------
// Polar/rectangular converter checker
// Port-level properties of the converter, attached to every instance.
// ---------------------------------------------------------------------------
module prc_checker #(
  parameter int DATA_WIDTH = 16
) (
  input logic                                              clk,
  input logic                                              rst,
  input logic                                              s_tready,
  input logic                                              m_tvalid,
  input logic                                              m_tready,
  input logic [prc_pkg::byte_pad(2*(DATA_WIDTH+1))-1:0]    m_tdata,
  input logic                                              m_tuser
);

  localparam int OW = DATA_WIDTH + 1;

  // Reset empties the output buffer and opens the input.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("output buffer not empty after reset");

  // A result that is not taken stays as it is.
  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // An invalid angle comes with a zero hypotenuse and a zero angle.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tuser |-> m_tdata[2*OW-1:0] == '0)
    else $error("invalid angle with nonzero results");

  // The input closes only after a result has been held back downstream.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
      !s_tready |-> $past(m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

endmodule

bind polar_rectangular_converter prc_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_prc_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
